[hdl/rsl_pkg.sv]
// Shared constants, codes and types of the run-slice line drawer.
package rsl_pkg;

	localparam int MAX_SCREEN_SIZE_DEF = 1024;

	localparam int CFG_W  = 11;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 11'd480;

	// Register index, taken from paddr[2].
	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	// Item kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam int IN_COORD_W  = 16;
	localparam int OUT_COORD_W = 10;
	localparam int OFFSET_W    = 20;
	localparam int COLOUR_W    = 32;

	localparam int QUEUE_DEPTH = 2;

	// A queued command holds four coordinates plus kind, case, direction and colour.
	localparam int CMD_COORDS  = 4;
	localparam int CMD_FIXED_W = 1 + 3 + 1 + COLOUR_W;

	typedef enum logic [2:0] {
		CASE_VERT   = 3'd0,
		CASE_HORIZ  = 3'd1,
		CASE_DIAG   = 3'd2,
		CASE_XMAJOR = 3'd3,
		CASE_YMAJOR = 3'd4
	} line_case_t;

	typedef enum logic [1:0] {
		PHASE_START  = 2'd0,
		PHASE_MIDDLE = 2'd1,
		PHASE_END    = 2'd2
	} slice_phase_t;

	typedef enum logic [1:0] {
		ST_READY  = 2'd0,
		ST_DIVIDE = 2'd1,
		ST_SETUP  = 2'd2
	} back_state_t;

endpackage

[hdl/rsl_queue.sv]
// Small first-in first-out queue between the front and the back of the drawer.
module rsl_queue #(
	parameter int DATA_W = 1,
	parameter int DEPTH  = rsl_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int PW   = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CNTW-1:0]   count_q;

	assign full     = (count_q == CNTW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNTW'(1);
				2'b01:   count_q <= count_q - CNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hdl/rsl_front.sv]
// Front end: takes input items, clamps and orders endpoints, and classifies the line.
module rsl_front #(
	parameter int MAX_SCREEN_SIZE = rsl_pkg::MAX_SCREEN_SIZE_DEF,
	parameter int CW    = $clog2(MAX_SCREEN_SIZE),
	parameter int SW    = $clog2(MAX_SCREEN_SIZE + 1),
	parameter int CMD_W = rsl_pkg::CMD_COORDS * CW + rsl_pkg::CMD_FIXED_W
) (
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   kind,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0]  x_start,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0]  y_start,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0]  x_end,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0]  y_end,
	input  logic        [rsl_pkg::COLOUR_W-1:0]    line_colour,
	input  logic        [SW-1:0]                   w_eff,
	input  logic        [SW-1:0]                   h_eff,
	input  logic                                   queue_full,
	output logic                                   push,
	output logic        [CMD_W-1:0]                cmd
);

	function automatic logic [CW-1:0] clamp_coord(
		input logic signed [rsl_pkg::IN_COORD_W-1:0] v,
		input logic [SW-1:0] lim
	);
		logic signed [rsl_pkg::IN_COORD_W:0] lim_s;
		logic signed [rsl_pkg::IN_COORD_W:0] v_s;
		lim_s = $signed({1'b0, rsl_pkg::IN_COORD_W'(lim)});
		v_s   = v;
		if (v_s < 0) begin
			return '0;
		end else if (v_s >= lim_s) begin
			return CW'(lim - SW'(1));
		end else begin
			return CW'(v);
		end
	endfunction

	logic [CW-1:0]       xa, ya, xb, yb;
	logic [CW-1:0]       x1, y1, x2, y2;
	logic                x_neg;
	logic [CW-1:0]       adx, dy;
	rsl_pkg::line_case_t lcase;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;

	always_comb begin
		xa = clamp_coord(x_start, w_eff);
		ya = clamp_coord(y_start, h_eff);
		xb = clamp_coord(x_end, w_eff);
		yb = clamp_coord(y_end, h_eff);
		// Order the endpoints so that y never falls along the line.
		if (ya > yb) begin
			x1 = xb; y1 = yb; x2 = xa; y2 = ya;
		end else begin
			x1 = xa; y1 = ya; x2 = xb; y2 = yb;
		end
		x_neg = (x2 < x1);
		adx   = x_neg ? (x1 - x2) : (x2 - x1);
		dy    = y2 - y1;
		priority if (adx == '0) begin
			lcase = rsl_pkg::CASE_VERT;
		end else if (dy == '0) begin
			lcase = rsl_pkg::CASE_HORIZ;
		end else if (adx == dy) begin
			lcase = rsl_pkg::CASE_DIAG;
		end else if (adx > dy) begin
			lcase = rsl_pkg::CASE_XMAJOR;
		end else begin
			lcase = rsl_pkg::CASE_YMAJOR;
		end
	end

	assign cmd = {kind, lcase, x_neg, x1, y1, adx, dy, line_colour};

endmodule

[hdl/rsl_back.sv]
// Back end: divider for slice setup, pixel stepping and the output register.
module rsl_back #(
	parameter int MAX_SCREEN_SIZE = rsl_pkg::MAX_SCREEN_SIZE_DEF,
	parameter int CW    = $clog2(MAX_SCREEN_SIZE),
	parameter int SW    = $clog2(MAX_SCREEN_SIZE + 1),
	parameter int CMD_W = rsl_pkg::CMD_COORDS * CW + rsl_pkg::CMD_FIXED_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              queue_empty,
	input  logic [CMD_W-1:0]                  cmd,
	output logic                              pop,
	input  logic [SW-1:0]                     w_eff,
	output logic                              pixel_valid,
	input  logic                              pixel_stall,
	output logic [rsl_pkg::OUT_COORD_W-1:0]   pixel_x,
	output logic [rsl_pkg::OUT_COORD_W-1:0]   pixel_y,
	output logic [rsl_pkg::OFFSET_W-1:0]      pixel_offset,
	output logic [rsl_pkg::COLOUR_W-1:0]      pixel_colour,
	output logic                              last_pixel
);

	localparam int PLW = CW + 1;
	localparam int EW  = CW + 3;
	localparam int DCW = $clog2(CW + 1);
	localparam int PRW = CW + SW;

	// Command fields.
	logic                        c_kind;
	logic [2:0]                  c_case_raw;
	logic                        c_xneg;
	logic [CW-1:0]               c_x, c_y, c_adx, c_dy;
	logic [rsl_pkg::COLOUR_W-1:0] c_colour;
	rsl_pkg::line_case_t         c_case;

	// Line state.
	rsl_pkg::back_state_t        state_q, state_d;
	logic                        active_q;
	rsl_pkg::line_case_t         case_q;
	rsl_pkg::slice_phase_t       phase_q;
	logic [CW-1:0]               cur_x_q, cur_y_q;
	logic                        x_neg_q;
	logic [rsl_pkg::COLOUR_W-1:0] colour_q;
	logic signed [EW-1:0]        err_q;
	logic [CW-1:0]               min_run_q;
	logic [CW:0]                 frac_q, turn_q;
	logic [PLW-1:0]              pl_q;
	logic [CW-1:0]               runs_q;
	logic [CW-1:0]               end_run_q;

	// Divider.
	logic [CW-1:0]               rem_q, quo_q, minor_q;
	logic [DCW-1:0]              div_cnt_q;
	logic [CW:0]                 trial;
	logic                        trial_ge;

	// Output register.
	logic                        out_valid_q;
	logic [rsl_pkg::OUT_COORD_W-1:0] pix_x_q, pix_y_q;
	logic [rsl_pkg::OFFSET_W-1:0]    pix_off_q;
	logic [rsl_pkg::COLOUR_W-1:0]    pix_col_q;
	logic                            pix_last_q;

	// Control strobes.
	logic out_free, take_start, do_tick, div_step, do_setup, start_slices;

	// Tick results.
	logic                        slice, step_x, step_y, run_end, t_last;
	logic [PLW-1:0]              pl_dec, t_pl;
	logic [CW-1:0]               t_x, t_y, t_runs, rl_dec;
	rsl_pkg::slice_phase_t       t_phase;
	logic signed [EW-1:0]        t_err, err_sum;
	logic [PRW-1:0]              prod;
	logic [PRW:0]                offset_sum;

	// Setup results.
	logic signed [EW-1:0]        s_err, odd_add;
	logic [CW-1:0]               s_end_run;
	logic [PLW-1:0]              s_pl;

	assign {c_kind, c_case_raw, c_xneg, c_x, c_y, c_adx, c_dy, c_colour} = cmd;
	assign c_case       = rsl_pkg::line_case_t'(c_case_raw);
	assign start_slices = (c_case == rsl_pkg::CASE_XMAJOR) || (c_case == rsl_pkg::CASE_YMAJOR);
	assign out_free     = !out_valid_q || !pixel_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsl_pkg::ST_READY: begin
				if (!queue_empty && c_kind == rsl_pkg::KIND_START && start_slices) begin
					state_d = rsl_pkg::ST_DIVIDE;
				end
			end
			rsl_pkg::ST_DIVIDE: begin
				if (div_cnt_q == DCW'(CW - 1)) begin
					state_d = rsl_pkg::ST_SETUP;
				end
			end
			rsl_pkg::ST_SETUP: state_d = rsl_pkg::ST_READY;
			default:           state_d = rsl_pkg::ST_READY;
		endcase
	end

	// Control outputs.
	always_comb begin
		pop        = 1'b0;
		take_start = 1'b0;
		do_tick    = 1'b0;
		div_step   = 1'b0;
		do_setup   = 1'b0;
		unique case (state_q)
			rsl_pkg::ST_READY: begin
				if (!queue_empty) begin
					priority if (c_kind == rsl_pkg::KIND_START) begin
						pop        = 1'b1;
						take_start = 1'b1;
					end else if (!active_q) begin
						// A tick with no line in progress is dropped.
						pop = 1'b1;
					end else if (out_free) begin
						pop     = 1'b1;
						do_tick = 1'b1;
					end
				end
			end
			rsl_pkg::ST_DIVIDE: div_step = 1'b1;
			rsl_pkg::ST_SETUP:  do_setup = 1'b1;
			default: ;
		endcase
	end

	// One restoring division step per cycle.
	always_comb begin
		trial    = {rem_q, quo_q[CW-1]};
		trial_ge = (trial >= {1'b0, minor_q});
	end

	// Slice parameters from quotient and remainder.
	always_comb begin
		odd_add   = quo_q[0] ? $signed(EW'(minor_q)) : $signed(EW'(0));
		s_err     = $signed(EW'(rem_q)) - $signed(EW'({minor_q, 1'b0})) + odd_add;
		s_end_run = CW'(quo_q >> 1) + CW'(1);
		s_pl      = PLW'(s_end_run) - ((!quo_q[0] && rem_q == '0) ? PLW'(1) : PLW'(0));
	end

	// Pixel step.
	always_comb begin
		pl_dec  = (pl_q != '0) ? pl_q - PLW'(1) : '0;
		run_end = (pl_dec == '0);
		slice   = (case_q == rsl_pkg::CASE_XMAJOR) || (case_q == rsl_pkg::CASE_YMAJOR);
		step_x  = 1'b0;
		step_y  = 1'b0;
		unique case (case_q)
			rsl_pkg::CASE_VERT:   step_y = 1'b1;
			rsl_pkg::CASE_HORIZ:  step_x = 1'b1;
			rsl_pkg::CASE_DIAG: begin
				step_x = 1'b1;
				step_y = 1'b1;
			end
			rsl_pkg::CASE_XMAJOR: begin
				step_x = 1'b1;
				step_y = run_end;
			end
			rsl_pkg::CASE_YMAJOR: begin
				step_y = 1'b1;
				step_x = run_end;
			end
			default: ;
		endcase
		t_x    = step_x ? (x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1)) : cur_x_q;
		t_y    = step_y ? cur_y_q + CW'(1) : cur_y_q;
		t_last = slice ? (run_end && phase_q == rsl_pkg::PHASE_END) : run_end;

		t_phase = phase_q;
		t_pl    = pl_dec;
		t_runs  = runs_q;
		t_err   = err_q;
		rl_dec  = runs_q;
		err_sum = err_q + $signed(EW'(frac_q));
		if (slice && run_end && phase_q != rsl_pkg::PHASE_END) begin
			if (phase_q == rsl_pkg::PHASE_MIDDLE && runs_q != '0) begin
				rl_dec = runs_q - CW'(1);
			end
			t_runs = rl_dec;
			if (rl_dec != '0) begin
				t_phase = rsl_pkg::PHASE_MIDDLE;
				if (err_sum > 0) begin
					t_err = err_sum - $signed(EW'(turn_q));
					t_pl  = PLW'(min_run_q) + PLW'(1);
				end else begin
					t_err = err_sum;
					t_pl  = PLW'(min_run_q);
				end
			end else begin
				t_phase = rsl_pkg::PHASE_END;
				t_pl    = PLW'(end_run_q);
			end
		end

		prod       = PRW'(cur_y_q) * PRW'(w_eff);
		offset_sum = (PRW + 1)'(prod) + (PRW + 1)'(cur_x_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsl_pkg::ST_READY;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_start) begin
				active_q <= 1'b1;
			end else if (do_tick && t_last) begin
				active_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= do_tick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_start) begin
			cur_x_q   <= c_x;
			cur_y_q   <= c_y;
			x_neg_q   <= c_xneg;
			colour_q  <= c_colour;
			case_q    <= c_case;
			phase_q   <= rsl_pkg::PHASE_START;
			pl_q      <= PLW'((c_case == rsl_pkg::CASE_HORIZ) ? c_adx : c_dy) + PLW'(1);
			rem_q     <= '0;
			quo_q     <= (c_adx > c_dy) ? c_adx : c_dy;
			minor_q   <= (c_adx > c_dy) ? c_dy : c_adx;
			div_cnt_q <= '0;
		end
		if (div_step) begin
			rem_q     <= trial_ge ? CW'(trial - {1'b0, minor_q}) : CW'(trial);
			quo_q     <= CW'({quo_q, trial_ge});
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
		if (do_setup) begin
			min_run_q <= quo_q;
			frac_q    <= {rem_q, 1'b0};
			turn_q    <= {minor_q, 1'b0};
			err_q     <= s_err;
			end_run_q <= s_end_run;
			pl_q      <= s_pl;
			runs_q    <= minor_q - CW'(1);
		end
		if (do_tick) begin
			cur_x_q    <= t_x;
			cur_y_q    <= t_y;
			phase_q    <= t_phase;
			pl_q       <= t_pl;
			runs_q     <= t_runs;
			err_q      <= t_err;
			pix_x_q    <= rsl_pkg::OUT_COORD_W'(cur_x_q);
			pix_y_q    <= rsl_pkg::OUT_COORD_W'(cur_y_q);
			pix_off_q  <= rsl_pkg::OFFSET_W'(offset_sum);
			pix_col_q  <= colour_q;
			pix_last_q <= t_last;
		end
	end

	assign pixel_valid  = out_valid_q;
	assign pixel_x      = pix_x_q;
	assign pixel_y      = pix_y_q;
	assign pixel_offset = pix_off_q;
	assign pixel_colour = pix_col_q;
	assign last_pixel   = pix_last_q;

endmodule

[hdl/run_slice_line_drawer.sv]
// Top level of the run-slice line drawer: configuration registers and the front, queue and back.
//
//  Channel   Direction  Handshake              Transfer carries
//  item      in         item_valid/item_stall  kind, x_start, y_start, x_end, y_end, line_colour
//  pixel     out        pixel_valid/pixel_stall pixel_x, pixel_y, pixel_offset, pixel_colour,
//                                               last_pixel
//  config    in         APB psel/penable/pready screen_width at 0x0, screen_height at 0x4
//
// Ticks flow at one pixel per cycle while pixels are taken; under stall a tick waits in the
// queue. A tick's pixel passes through the queue and the back end into the output register
// before it is offered. A start of a vertical, horizontal or diagonal line needs no division;
// any other start holds the back end in its divide and setup states while the one-bit-per-cycle
// divider forms run length and remainder. Reset clears the line, the queue and the output
// register, and sets the screen to 640 by 480. The front takes items while the two-entry
// queue has room, and the back keeps setting up lines while a finished pixel waits under stall.
module run_slice_line_drawer #(
	parameter int MAX_SCREEN_SIZE = rsl_pkg::MAX_SCREEN_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item channel.
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  kind,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0] x_start,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0] y_start,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0] x_end,
	input  logic signed [rsl_pkg::IN_COORD_W-1:0] y_end,
	input  logic        [rsl_pkg::COLOUR_W-1:0]   line_colour,
	// Pixel channel.
	output logic                                  pixel_valid,
	input  logic                                  pixel_stall,
	output logic        [rsl_pkg::OUT_COORD_W-1:0] pixel_x,
	output logic        [rsl_pkg::OUT_COORD_W-1:0] pixel_y,
	output logic        [rsl_pkg::OFFSET_W-1:0]    pixel_offset,
	output logic        [rsl_pkg::COLOUR_W-1:0]    pixel_colour,
	output logic                                  last_pixel,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic        [rsl_pkg::ADDR_W-1:0]     paddr,
	input  logic        [rsl_pkg::DATA_W-1:0]     pwdata,
	output logic        [rsl_pkg::DATA_W-1:0]     prdata,
	output logic                                  pready
);

	// Coordinates need log2 of the largest screen, rounded up; sizes need log2 of one more than it.
	localparam int CW    = $clog2(MAX_SCREEN_SIZE);
	localparam int SW    = $clog2(MAX_SCREEN_SIZE + 1);
	localparam int CMD_W = rsl_pkg::CMD_COORDS * CW + rsl_pkg::CMD_FIXED_W;

	logic [rsl_pkg::CFG_W-1:0] width_q;
	logic [rsl_pkg::CFG_W-1:0] height_q;
	logic [SW-1:0]             w_eff;
	logic [SW-1:0]             h_eff;

	logic             queue_full;
	logic             queue_empty;
	logic             push;
	logic             pop;
	logic [CMD_W-1:0] push_cmd;
	logic [CMD_W-1:0] pop_cmd;

	// The port never waits. Any address decodes to a register by its bit 2.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rsl_pkg::SCREEN_WIDTH_RESET;
			height_q <= rsl_pkg::SCREEN_HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				rsl_pkg::REG_SCREEN_WIDTH:  width_q  <= pwdata[rsl_pkg::CFG_W-1:0];
				rsl_pkg::REG_SCREEN_HEIGHT: height_q <= pwdata[rsl_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rsl_pkg::REG_SCREEN_WIDTH:  prdata = rsl_pkg::DATA_W'(width_q);
			rsl_pkg::REG_SCREEN_HEIGHT: prdata = rsl_pkg::DATA_W'(height_q);
			default:                    prdata = '0;
		endcase
	end

	// Register values outside 1..MAX_SCREEN_SIZE are limited to that range before use.
	always_comb begin
		if (width_q == '0) begin
			w_eff = SW'(1);
		end else if (32'(width_q) > MAX_SCREEN_SIZE) begin
			w_eff = SW'(MAX_SCREEN_SIZE);
		end else begin
			w_eff = SW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = SW'(1);
		end else if (32'(height_q) > MAX_SCREEN_SIZE) begin
			h_eff = SW'(MAX_SCREEN_SIZE);
		end else begin
			h_eff = SW'(height_q);
		end
	end

	// The front clamps, orders and classifies each item in the cycle it arrives.
	rsl_front #(
		.MAX_SCREEN_SIZE(MAX_SCREEN_SIZE),
		.CW             (CW),
		.SW             (SW),
		.CMD_W          (CMD_W)
	) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_colour(line_colour),
		.w_eff      (w_eff),
		.h_eff      (h_eff),
		.queue_full (queue_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// The queue lets the front keep taking items while the back divides or waits on stall.
	rsl_queue #(
		.DATA_W(CMD_W),
		.DEPTH (rsl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.pop_data (pop_cmd),
		.empty    (queue_empty)
	);

	// The back sets up lines, steps pixels and owns the output register.
	rsl_back #(
		.MAX_SCREEN_SIZE(MAX_SCREEN_SIZE),
		.CW             (CW),
		.SW             (SW),
		.CMD_W          (CMD_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.cmd         (pop_cmd),
		.pop         (pop),
		.w_eff       (w_eff),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_offset(pixel_offset),
		.pixel_colour(pixel_colour),
		.last_pixel  (last_pixel)
	);

endmodule

[hdl/rsl_checker.sv]
// Port-level checks of the run-slice line drawer, bound to its top level.
module rsl_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               pixel_valid,
	input logic                               pixel_stall,
	input logic [rsl_pkg::OUT_COORD_W-1:0]    pixel_x,
	input logic [rsl_pkg::OUT_COORD_W-1:0]    pixel_y,
	input logic [rsl_pkg::OFFSET_W-1:0]       pixel_offset,
	input logic [rsl_pkg::COLOUR_W-1:0]       pixel_colour,
	input logic                               last_pixel,
	input logic                               psel,
	input logic                               penable,
	input logic                               pwrite,
	input logic [rsl_pkg::ADDR_W-1:0]         paddr,
	input logic [rsl_pkg::DATA_W-1:0]         pwdata,
	input logic [rsl_pkg::DATA_W-1:0]         prdata
);

	// A waiting pixel stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid)
		else $error("pixel dropped while stalled");

	// A waiting pixel keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> $stable(pixel_x) && $stable(pixel_y) &&
			$stable(pixel_offset) && $stable(pixel_colour) && $stable(last_pixel))
		else $error("pixel payload changed while stalled");

	// Nothing is offered in the first cycle after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !pixel_valid)
		else $error("pixel offered straight out of reset");

	// A register reads back what was just written to it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(psel && penable && pwrite) && psel && !pwrite && paddr == $past(paddr)
			|-> prdata[rsl_pkg::CFG_W-1:0] == $past(pwdata[rsl_pkg::CFG_W-1:0]))
		else $error("register read does not return the last write");

endmodule

bind run_slice_line_drawer rsl_checker u_rsl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel_valid),
	.pixel_stall (pixel_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_offset(pixel_offset),
	.pixel_colour(pixel_colour),
	.last_pixel  (last_pixel),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata)
);

[bench/tb_run_slice_line_drawer.sv]
// Self-checking testbench of the run-slice line drawer with its own pixel predictor.
module tb_run_slice_line_drawer;

	timeunit 1ns;
	timeprecision 1ps;

	import rsl_pkg::*;

	localparam int SCREEN_MAX = MAX_SCREEN_SIZE_DEF;
	// A start that needs the divider holds the back end through its divide and setup states, and up
	// to two of them can sit in the queue, so this many quiet cycles leave the block idle.
	localparam int SETTLE_CYCLES   = 48;
	localparam int ITEMS_PER_PHASE = 95;
	localparam int RANDOM_PHASES   = 7;
	localparam int LONG_HOLD       = 150;
	localparam int TIMEOUT_NS      = 2000000;

	typedef struct packed {
		logic [OUT_COORD_W-1:0] x;
		logic [OUT_COORD_W-1:0] y;
		logic [OFFSET_W-1:0]    off;
		logic [COLOUR_W-1:0]    colour;
		logic                   last;
	} pixel_t;

	// One row of the directed table. When typed is set, the pixel (or its absence) is
	// written out in the row instead of being taken from the predictor.
	typedef struct packed {
		logic                          knd;
		logic signed [IN_COORD_W-1:0]  xs;
		logic signed [IN_COORD_W-1:0]  ys;
		logic signed [IN_COORD_W-1:0]  xe;
		logic signed [IN_COORD_W-1:0]  ye;
		logic [COLOUR_W-1:0]           col;
		logic                          typed;
		logic                          want_pixel;
		pixel_t                        pix;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           item_valid = 1'b0;
	logic                           item_stall;
	logic                           kind = KIND_START;
	logic signed [IN_COORD_W-1:0]   x_start = '0;
	logic signed [IN_COORD_W-1:0]   y_start = '0;
	logic signed [IN_COORD_W-1:0]   x_end = '0;
	logic signed [IN_COORD_W-1:0]   y_end = '0;
	logic [COLOUR_W-1:0]            line_colour = '0;

	logic                           pixel_valid;
	logic                           pixel_stall = 1'b0;
	logic [OUT_COORD_W-1:0]         pixel_x;
	logic [OUT_COORD_W-1:0]         pixel_y;
	logic [OFFSET_W-1:0]            pixel_offset;
	logic [COLOUR_W-1:0]            pixel_colour;
	logic                           last_pixel;

	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [ADDR_W-1:0]              paddr = '0;
	logic [DATA_W-1:0]              pwdata = '0;
	logic [DATA_W-1:0]              prdata;
	logic                           pready;

	run_slice_line_drawer #(.MAX_SCREEN_SIZE(SCREEN_MAX)) DUT (.*);

	// Pixels that the predictor says the block still owes, oldest first.
	pixel_t pending_pixels[$];
	int     fail_count = 0;
	int     items_done = 0;
	int     burst_left = 0;
	// Set by the stimulus to make the receiver hold off for a long stretch.
	bit     hold_req = 1'b0;

	// Predictor copy of the configuration registers.
	logic [CFG_W-1:0] scr_w = SCREEN_WIDTH_RESET;
	logic [CFG_W-1:0] scr_h = SCREEN_HEIGHT_RESET;

	// Predictor copy of the line state. The pen is the pixel that the next tick emits.
	bit           pen_on = 1'b0;
	line_case_t   seg_kind = CASE_VERT;
	slice_phase_t slice = PHASE_START;
	int           pen_x = 0;
	int           pen_y = 0;
	bit           step_back = 1'b0;
	logic [COLOUR_W-1:0] pen_colour = '0;
	int           err_acc = 0;
	int           base_run = 0;
	int           err_step = 0;
	int           err_wrap = 0;
	int           pen_left = 0;
	int           slices_left = 0;
	int           tail_len = 0;

	// The directed part: ticks with nothing to draw, single points at both corners of the
	// screen after clamping, each kind of line, and starts that cut a line short. The last
	// line is left half drawn so that the first register change lands in the middle of it.
	stim_row_t directed_rows [22] = '{
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b1, 1'b0, '0},
		'{KIND_START, -16'sd5, -16'sd7, -16'sd100, 16'sh8000, 32'hA5A5_5A5A, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b1, 1'b1,
			'{10'd0, 10'd0, 20'd0, 32'hA5A5_5A5A, 1'b1}},
		'{KIND_START, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF,
			1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b1, 1'b1,
			'{10'd639, 10'd479, 20'd307199, 32'hFFFF_FFFF, 1'b1}},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b1, 1'b0, '0},
		'{KIND_START, 16'sd10, 16'sd5, 16'sd10, 16'sd7, 32'h0000_0001, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_START, 16'sd20, 16'sd3, 16'sd17, 16'sd3, 32'h8000_0000, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_START, 16'sd5, 16'sd9, 16'sd8, 16'sd6, 32'h1234_5678, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_START, 16'sd0, 16'sd0, 16'sd7, 16'sd2, 32'h0F0F_0F0F, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_START, 16'sd3, 16'sd1000, 16'sd1, 16'sd0, 32'hF0F0_F0F0, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_START, -16'sd100, 16'sd2, 16'sd2000, 16'sd2, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0},
		'{KIND_TICK,  16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 1'b0, 1'b0, '0}
	};

	// A register value outside 1..SCREEN_MAX is pulled to the nearest end of that range.
	function automatic int visible_extent(input logic [CFG_W-1:0] r);
		if (r < 1) return 1;
		if (r > SCREEN_MAX) return SCREEN_MAX;
		return int'(r);
	endfunction

	function automatic int clip_coord(input int v, input int lim);
		if (v >= lim) v = lim - 1;
		if (v < 0) v = 0;
		return v;
	endfunction

	// Applies one transfer to the predicted line state. A start sets up the line and
	// returns 0; a tick returns 1 with the pixel it draws, or 0 when no line is active.
	function automatic bit draw_item(input logic knd, input logic signed [IN_COORD_W-1:0] xs,
			input logic signed [IN_COORD_W-1:0] ys, input logic signed [IN_COORD_W-1:0] xe,
			input logic signed [IN_COORD_W-1:0] ye, input logic [COLOUR_W-1:0] col,
			output pixel_t pix);
		int w, h, x1, y1, x2, y2, t, dx, dy, major, minor, q, r, dir, offs, run;
		bit run_end, last;
		pix = '0;
		w = visible_extent(scr_w);
		h = visible_extent(scr_h);
		if (knd == KIND_START) begin
			x1 = clip_coord(int'(xs), w);
			y1 = clip_coord(int'(ys), h);
			x2 = clip_coord(int'(xe), w);
			y2 = clip_coord(int'(ye), h);
			// Draw from the upper endpoint so that y only ever rises.
			if (y1 > y2) begin
				t = y1; y1 = y2; y2 = t;
				t = x1; x1 = x2; x2 = t;
			end
			pen_x = x1;
			pen_y = y1;
			pen_colour = col;
			dx = x2 - x1;
			dy = y2 - y1;
			step_back = dx < 0;
			if (dx < 0) dx = -dx;
			pen_on = 1'b1;
			slice = PHASE_START;
			if (dx == 0) begin
				seg_kind = CASE_VERT;
				pen_left = dy + 1;
			end else if (dy == 0) begin
				seg_kind = CASE_HORIZ;
				pen_left = dx + 1;
			end else if (dx == dy) begin
				seg_kind = CASE_DIAG;
				pen_left = dy + 1;
			end else begin
				seg_kind = (dx > dy) ? CASE_XMAJOR : CASE_YMAJOR;
				major = (dx > dy) ? dx : dy;
				minor = (dx > dy) ? dy : dx;
				q = major / minor;
				r = major % minor;
				base_run = q;
				err_step = 2 * r;
				err_wrap = 2 * minor;
				err_acc = r - err_wrap;
				// The first and last runs split one run between them; an odd run
				// length pushes the spare half pixel into the error term instead.
				tail_len = q / 2 + 1;
				pen_left = tail_len;
				if (q % 2 == 1) err_acc += minor;
				else if (err_step == 0) pen_left--;
				slices_left = minor - 1;
			end
			return 1'b0;
		end
		if (!pen_on) return 1'b0;

		dir = step_back ? -1 : 1;
		// The offset uses the width in effect now, not the one at the start of the line.
		offs = pen_x + pen_y * w;
		pix.x = pen_x[OUT_COORD_W-1:0];
		pix.y = pen_y[OUT_COORD_W-1:0];
		pix.off = offs[OFFSET_W-1:0];
		pix.colour = pen_colour;
		last = 1'b0;
		if (pen_left > 0) pen_left--;
		run_end = (pen_left == 0);
		case (seg_kind)
			CASE_VERT: begin
				pen_y++;
				last = run_end;
			end
			CASE_HORIZ: begin
				pen_x += dir;
				last = run_end;
			end
			CASE_DIAG: begin
				pen_x += dir;
				pen_y++;
				last = run_end;
			end
			default: begin
				if (seg_kind == CASE_XMAJOR) begin
					pen_x += dir;
					if (run_end) pen_y++;
				end else begin
					pen_y++;
					if (run_end) pen_x += dir;
				end
				if (run_end) begin
					if (slice == PHASE_END) begin
						last = 1'b1;
					end else begin
						if (slice == PHASE_MIDDLE && slices_left > 0) slices_left--;
						if (slices_left > 0) begin
							// A middle run is lengthened whenever the error crosses zero.
							slice = PHASE_MIDDLE;
							run = base_run;
							err_acc += err_step;
							if (err_acc > 0) begin
								err_acc -= err_wrap;
								run++;
							end
							pen_left = run;
						end else begin
							slice = PHASE_END;
							pen_left = tail_len;
						end
					end
				end
			end
		endcase
		if (last) pen_on = 1'b0;
		pix.last = last;
		return 1'b1;
	endfunction

	// The sender works in bursts; between bursts it drops valid for a random gap.
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Offers one item, waits for its transfer and runs it through the predictor.
	task automatic offer_item(input logic knd, input logic signed [IN_COORD_W-1:0] xs,
			input logic signed [IN_COORD_W-1:0] ys, input logic signed [IN_COORD_W-1:0] xe,
			input logic signed [IN_COORD_W-1:0] ye, input logic [COLOUR_W-1:0] col,
			output bit produced, output pixel_t pix);
		pace();
		item_valid <= 1'b1;
		kind <= knd;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		line_colour <= col;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		produced = draw_item(knd, xs, ys, xe, ye, col, pix);
		if (knd == KIND_START || produced) items_done++;
	endtask

	task automatic send(input logic knd, input logic signed [IN_COORD_W-1:0] xs,
			input logic signed [IN_COORD_W-1:0] ys, input logic signed [IN_COORD_W-1:0] xe,
			input logic signed [IN_COORD_W-1:0] ye, input logic [COLOUR_W-1:0] col);
		bit produced;
		pixel_t pix;
		offer_item(knd, xs, ys, xe, ye, col, produced, pix);
		if (produced) pending_pixels.push_back(pix);
	endtask

	// A tick carries random coordinates and colour, which the block must ignore.
	task automatic send_tick();
		send(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
	endtask

	// Stops offering, waits for every owed pixel, then gives the back end time to finish
	// any start that is still being divided.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One APB transfer: a setup cycle, then an access cycle that ends when pready is high.
	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes a screen register with junk in the unused upper bits and reads it back.
	task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
		logic [DATA_W-1:0] readback;
		apb_access(1'b1, {idx, 2'b00}, {21'($urandom), value}, readback);
		if (idx == REG_SCREEN_WIDTH) scr_w = value;
		else scr_h = value;
		apb_access(1'b0, {idx, 2'b00}, '0, readback);
		if (readback !== {{(DATA_W - CFG_W){1'b0}}, value}) begin
			$display("%0t: register %0d read back expected %0d got %0d", $time, idx, value,
				readback);
			fail_count++;
		end
	endtask

	// One line of the random part. Most lines are short and drawn to their end; a few are
	// cut short by the next start, some are long, and some items are plain noise.
	task automatic random_line();
		int w, h, sel, d, cap, n;
		logic signed [IN_COORD_W-1:0] xs, ys, xe, ye;
		w = visible_extent(scr_w);
		h = visible_extent(scr_h);
		sel = $urandom_range(0, 11);
		d = $urandom_range(1, 24);
		// Endpoints land near the screen, a few pixels past its edges now and then.
		xs = 16'(int'($urandom_range(0, w + 15)) - 8);
		ys = 16'(int'($urandom_range(0, h + 15)) - 8);
		xe = 16'(int'(xs) + int'($urandom_range(0, 48)) - 24);
		ye = 16'(int'(ys) + int'($urandom_range(0, 48)) - 24);
		case (sel)
			0: xe = xs;
			1: ye = ys;
			2: begin
				xe = 16'(int'(xs) + ($urandom_range(0, 1) ? d : -d));
				ye = 16'(int'(ys) + ($urandom_range(0, 1) ? d : -d));
			end
			7: begin
				xs = 16'($urandom_range(0, w - 1));
				ys = 16'($urandom_range(0, h - 1));
				xe = 16'($urandom_range(0, w - 1));
				ye = 16'($urandom_range(0, h - 1));
			end
			8, 9: begin
				xs = 16'($urandom);
				ys = 16'($urandom);
				xe = 16'($urandom);
				ye = 16'($urandom);
			end
			10: begin
				xs = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				ye = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			end
			11: begin
				send(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), $urandom);
				return;
			end
			default: ;
		endcase
		send(KIND_START, xs, ys, xe, ye, $urandom);
		if ($urandom_range(0, 15) == 0) cap = 300;
		else if ($urandom_range(0, 5) == 0) cap = $urandom_range(0, 3);
		else cap = 40;
		n = 0;
		while (pen_on && n < cap) begin
			send_tick();
			n++;
		end
		// Sometimes tick once more; after a finished line that tick must draw nothing.
		if ($urandom_range(0, 7) == 0) send_tick();
	endtask

	// Field-by-field comparison of one transferred pixel.
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// Pixel monitor: every pixel transfer is matched against the oldest owed pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0d y=%0d expected none", $time,
					pixel_x, pixel_y);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("pixel_x", want.x, pixel_x);
				check_field("pixel_y", want.y, pixel_y);
				check_field("pixel_offset", want.off, pixel_offset);
				check_field("pixel_colour", want.colour, pixel_colour);
				check_field("last_pixel", want.last, last_pixel);
			end
		end
	end

	// Receiver: stall in segments of random length, each with its own pattern. On
	// request it holds off for a long stretch so that the block fills and stalls its input.
	initial begin : receiver
		int seg_len, mode;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				mode = 4;
				seg_len = LONG_HOLD;
			end else begin
				mode = $urandom_range(0, 3);
				seg_len = $urandom_range(1, 60);
			end
			repeat (seg_len) begin
				@(posedge clk);
				case (mode)
					0: pixel_stall <= 1'b0;
					1: pixel_stall <= ($urandom_range(0, 2) == 0);
					2: pixel_stall <= ($urandom_range(0, 3) != 0);
					3: pixel_stall <= ~pixel_stall;
					default: pixel_stall <= 1'b1;
				endcase
			end
		end
	end

	// Stimulus: the directed table, then random phases, each under its own screen size.
	initial begin : stimulus
		int target;
		bit produced;
		pixel_t pix;
		logic [CFG_W-1:0] w_set, h_set;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer_item(directed_rows[i].knd, directed_rows[i].xs, directed_rows[i].ys,
				directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].col,
				produced, pix);
			if (directed_rows[i].typed) begin
				if (directed_rows[i].want_pixel) pending_pixels.push_back(directed_rows[i].pix);
			end else if (produced) begin
				pending_pixels.push_back(pix);
			end
		end

		for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
			// Registers change only while nothing is in flight. The first change comes
			// while the last directed line is still half drawn.
			settle();
			case (phase)
				1: begin w_set = 11'd1024; h_set = 11'd1024; end
				2: begin w_set = 11'd1;    h_set = 11'd1;    end
				3: begin w_set = 11'd0;    h_set = 11'd2047; end
				4: begin w_set = 11'd2047; h_set = 11'd0;    end
				5: begin w_set = 11'd1025; h_set = 11'd37;   end
				6: begin
					w_set = 11'($urandom_range(2, 64));
					h_set = 11'($urandom_range(2, 64));
				end
				default: begin
					w_set = 11'($urandom_range(1, 1024));
					h_set = 11'($urandom_range(1, 1024));
				end
			endcase
			write_register(REG_SCREEN_WIDTH, w_set);
			write_register(REG_SCREEN_HEIGHT, h_set);
			hold_req = 1'b1;
			// A few ticks first, to draw on from whatever line survived the register change.
			repeat ($urandom_range(2, 6)) send_tick();
			target = items_done + ITEMS_PER_PHASE;
			while (items_done < target) begin
				random_line();
				// Now and then the sender waits until every owed pixel has arrived.
				if ($urandom_range(0, 39) == 0) settle();
			end
		end

		settle();
		if (fail_count == 0)
			$display("run_slice_line_drawer verification clean");
		else
			$display("run_slice_line_drawer verification failed");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("run_slice_line_drawer verification failed");
		$finish;
	end

endmodule

[files.f]
hdl/rsl_pkg.sv
hdl/rsl_queue.sv
hdl/rsl_front.sv
hdl/rsl_back.sv
hdl/run_slice_line_drawer.sv
hdl/rsl_checker.sv
bench/tb_run_slice_line_drawer.sv
